// ----- hw/rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// Tree geometry, request/result beats, controller command and status groups.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Tree geometry, all derived from the leaf count (a power of two)
  localparam int LEAF_LOG2  = 10;
  localparam int LEAF_PAGES = 1 << LEAF_LOG2;
  localparam int ROWS       = LEAF_PAGES - 1;          // one row per inner node
  localparam int ROW_W      = LEAF_LOG2;
  localparam int IDX_W      = LEAF_LOG2 + 1;           // heap index, 2*LEAF-1 nodes
  localparam int SIZE_W     = LEAF_LOG2 + 1;           // node value 0..LEAF_PAGES
  localparam int DEPTH_W    = $clog2(LEAF_LOG2 + 1);

  // Beat field widths
  localparam int REQ_W = 11;
  localparam int OFS_W = 10;

  localparam logic [SIZE_W-1:0] LEAF_SIZE = SIZE_W'(LEAF_PAGES);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [REQ_W-1:0] request_pages;
    logic [OFS_W-1:0] page_offset_in;
  } req_t;

  typedef struct packed {
    logic [OFS_W-1:0] page_offset_out;
    logic [REQ_W-1:0] freed_pages;
    logic             fail;
  } result_t;

  // Controller -> datapath
  typedef struct packed {
    logic init_step;   // clearing pass: write one row
    logic load;        // latch a request
    logic rd;          // read children row of current node
    logic step;        // descend one level using read data
    logic asc_setup;   // prepare the upward pass
    logic asc_step;    // write node, move to parent
    logic set_fail;
    logic report;      // emit the result beat
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic init_last;
    logic req_bad;
    logic desc_end;
    logic free_miss;
    logic at_root;
  } ctrl_stat_t;

  // Round up to a power of two, zero counts as one
  function automatic logic [REQ_W:0] round_pow2(input logic [REQ_W-1:0] n);
    logic [REQ_W-1:0] m;
    logic [REQ_W:0]   p;
    m = (n == '0) ? '0 : n - REQ_W'(1);
    p = (REQ_W+1)'(1);
    for (int i = 0; i < REQ_W; i++) begin
      if (m[i]) p = (REQ_W+1)'(1) << (i + 1);
    end
    return p;
  endfunction

endpackage

// ----- hw/rtl/bpa_tree_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_tree_mem: node store of the allocation tree
// One row per inner node, holding its left and right child values.
// ----------------------------------------------------------------------------
module bpa_tree_mem (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [bpa_pkg::ROW_W-1:0]   rd_row,
  output logic [bpa_pkg::SIZE_W-1:0]  rd_l,
  output logic [bpa_pkg::SIZE_W-1:0]  rd_r,
  input  logic                        wr_l,
  input  logic                        wr_r,
  input  logic [bpa_pkg::ROW_W-1:0]   wr_row,
  input  logic [bpa_pkg::SIZE_W-1:0]  wr_data
);

  logic [bpa_pkg::SIZE_W-1:0] mem_l [bpa_pkg::ROWS];
  logic [bpa_pkg::SIZE_W-1:0] mem_r [bpa_pkg::ROWS];

  always_ff @(posedge clk) begin
    if (wr_l) mem_l[wr_row] <= wr_data;
    if (wr_r) mem_r[wr_row] <= wr_data;
    if (rd_en) begin
      rd_l <= mem_l[rd_row];
      rd_r <= mem_r[rd_row];
    end
  end

endmodule

// ----- hw/rtl/bpa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath: tree walk registers, node merge and result beat
// Descends one level per command, records siblings, climbs back writing nodes.
// ----------------------------------------------------------------------------
module bpa_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  bpa_pkg::ctrl_cmd_t     cmd,
  input  bpa_pkg::req_t          request,
  output bpa_pkg::ctrl_stat_t    st,
  output logic                   done,
  output bpa_pkg::result_t       result
);

  localparam int SW = bpa_pkg::SIZE_W;
  localparam int RW = bpa_pkg::ROW_W;
  localparam int IW = bpa_pkg::IDX_W;
  localparam int DW = bpa_pkg::DEPTH_W;

  // root node lives in a register, the rest in the row store
  logic [SW-1:0] root;
  logic [RW-1:0] init_row;
  logic [SW-1:0] init_val;

  logic          op;
  logic          too_big;
  logic          page_big;
  logic [SW-1:0] size;
  logic [RW-1:0] page;
  logic [IW-1:0] idx;
  logic [DW-1:0] depth;
  logic [RW-1:0] offset;
  logic [RW-1:0] mask;
  logic [SW-1:0] cur;
  logic          zero_found;
  logic [DW-1:0] zero_depth;
  logic [IW-1:0] zero_idx;
  logic          fail_flag;
  logic [SW-1:0] sib [bpa_pkg::LEAF_LOG2+1];

  logic [SW-1:0] rd_l, rd_r;
  logic          wr_l, wr_r;
  logic [RW-1:0] wr_row;
  logic [SW-1:0] wr_data;

  logic [bpa_pkg::REQ_W:0] rounded;
  logic [SW-1:0]           nodesize;
  logic                    go_left;
  logic [SW-1:0]           child_v, sib_v;
  logic [IW-1:0]           idx_child;
  logic [DW-1:0]           depth_inc;
  logic [IW-1:0]           parent;
  logic [SW-1:0]           psize;
  logic [SW:0]             pair_sum;
  logic [SW-1:0]           merged;
  logic [RW:0]             init_nx;

  assign rounded   = bpa_pkg::round_pow2(request.request_pages);
  assign nodesize  = bpa_pkg::LEAF_SIZE >> depth;
  assign depth_inc = depth + DW'(1);

  // allocate: best fit; free: follow the page's bits
  always_comb begin
    if (op == bpa_pkg::OP_ALLOC) begin
      go_left = (rd_r < size) || ((size <= rd_l) && (rd_l <= rd_r));
    end else begin
      go_left = ~|(page & mask);
    end
    child_v   = go_left ? rd_l : rd_r;
    sib_v     = go_left ? rd_r : rd_l;
    idx_child = {idx[IW-2:0], 1'b0} + (go_left ? IW'(1) : IW'(2));
  end

  // upward merge: two full buddies join, else the larger one
  always_comb begin
    parent   = (idx - IW'(1)) >> 1;
    psize    = bpa_pkg::LEAF_SIZE >> (depth - DW'(1));
    pair_sum = {1'b0, cur} + {1'b0, sib[depth]};
    if (pair_sum == {1'b0, psize}) merged = psize;
    else                           merged = (cur > sib[depth]) ? cur : sib[depth];
  end

  assign init_nx = {1'b0, init_row} + (RW+1)'(1);

  always_comb begin
    wr_l    = cmd.init_step | (cmd.asc_step & (depth != '0) & idx[0]);
    wr_r    = cmd.init_step | (cmd.asc_step & (depth != '0) & ~idx[0]);
    wr_row  = cmd.init_step ? init_row : parent[RW-1:0];
    wr_data = cmd.init_step ? init_val : cur;
  end

  bpa_tree_mem u_mem (
    .clk     (clk),
    .rd_en   (cmd.rd),
    .rd_row  (idx[RW-1:0]),
    .rd_l    (rd_l),
    .rd_r    (rd_r),
    .wr_l    (wr_l),
    .wr_r    (wr_r),
    .wr_row  (wr_row),
    .wr_data (wr_data)
  );

  // control state: clearing pass, root, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      init_row <= '0;
      init_val <= bpa_pkg::LEAF_SIZE >> 1;
      root     <= bpa_pkg::LEAF_SIZE;
      done     <= 1'b0;
    end else begin
      done <= cmd.report;
      if (cmd.init_step) begin
        init_row <= init_nx[RW-1:0];
        // next row starts a new level when row+2 is a power of two
        if (((init_nx + (RW+1)'(1)) & init_nx) == '0) init_val <= init_val >> 1;
      end
      if (cmd.asc_step && depth == '0) root <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= request.operation;
      too_big    <= {1'b0, request.request_pages} > (bpa_pkg::REQ_W+1)'(bpa_pkg::LEAF_PAGES);
      page_big   <= SW'(request.page_offset_in) >= bpa_pkg::LEAF_SIZE;
      size       <= SW'(rounded);
      page       <= RW'(request.page_offset_in);
      idx        <= '0;
      depth      <= '0;
      offset     <= '0;
      mask       <= RW'(1) << (RW - 1);
      zero_found <= (root == '0);
      zero_depth <= '0;
      zero_idx   <= '0;
      fail_flag  <= 1'b0;
    end
    if (cmd.set_fail) fail_flag <= 1'b1;
    if (cmd.step) begin
      sib[depth_inc] <= sib_v;
      idx            <= idx_child;
      depth          <= depth_inc;
      mask           <= mask >> 1;
      if (!go_left) offset <= offset | mask;
      if (child_v == '0) begin
        zero_found <= 1'b1;
        zero_depth <= depth_inc;
        zero_idx   <= idx_child;
      end
    end
    if (cmd.asc_setup) begin
      if (op == bpa_pkg::OP_FREE) begin
        idx   <= zero_idx;
        depth <= zero_depth;
        cur   <= bpa_pkg::LEAF_SIZE >> zero_depth;
      end else begin
        cur   <= '0;
      end
    end
    if (cmd.asc_step && depth != '0) begin
      cur   <= merged;
      idx   <= parent;
      depth <= depth - DW'(1);
    end
    if (cmd.report) begin
      result.fail            <= fail_flag;
      result.page_offset_out <= (fail_flag || op == bpa_pkg::OP_FREE) ? '0
                                : bpa_pkg::OFS_W'(offset);
      result.freed_pages     <= (fail_flag || op == bpa_pkg::OP_ALLOC) ? '0
                                : bpa_pkg::REQ_W'(bpa_pkg::LEAF_SIZE >> zero_depth);
    end
  end

  always_comb begin
    st.init_last = (init_row == RW'(bpa_pkg::ROWS - 1));
    st.req_bad   = (op == bpa_pkg::OP_ALLOC) ? (too_big || size > root) : page_big;
    st.desc_end  = (op == bpa_pkg::OP_ALLOC) ? (nodesize == size)
                                             : (depth == DW'(bpa_pkg::LEAF_LOG2));
    st.free_miss = (op == bpa_pkg::OP_FREE) && !zero_found;
    st.at_root   = (depth == '0);
  end

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl: sequencer of the buddy page allocator
// Clearing pass, request check, tree descent, climb and result beat.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  bpa_pkg::ctrl_stat_t   st,
  output bpa_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_CLIMB  = 7'b0100000,
    ST_REPORT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.req_bad) begin
          cmd.set_fail = 1'b1;
          state_next   = ST_REPORT;
        end else begin
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        if (st.desc_end) begin
          if (st.free_miss) begin
            cmd.set_fail = 1'b1;
            state_next   = ST_REPORT;
          end else begin
            cmd.asc_setup = 1'b1;
            state_next    = ST_CLIMB;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step   = 1'b1;
        state_next = ST_READ;
      end
      ST_CLIMB: begin
        cmd.asc_step = 1'b1;
        if (st.at_root) state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- hw/rtl/buddy_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator over a fixed set of pages
// Sequencer plus datapath around a row store of the largest-free tree.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a rising edge with start high and busy low.
//   operation 0 allocates request_pages (rounded up to a power of two, zero
//   counts as one) and returns page_offset_out; operation 1 frees the block
//   holding page_offset_in and returns its size in freed_pages. fail marks a
//   request that does not fit or a free of a page that is not allocated.
//   The result beat shows on result for one cycle with done high; it cannot
//   be held off, so the receiver must take it then.
// Timing:
//   One beat at a time; the next beat may be taken in the done cycle. Each
//   tree level costs a row read, then a compare, on the way down and a node
//   write on the way up. Allocate descends to the block's depth; free walks
//   down to the page's leaf, then climbs from the freed block. A request
//   refused at the check (too large) reports without a walk; a free of a
//   page that is not allocated walks the whole path, then fails.
// Reset:
//   After rst all 1023 rows of the store are swept, one row per cycle, to
//   their all-free values with busy high; requests are taken once busy drops.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bpa_pkg::req_t     request,
  output logic              busy,
  output logic              done,
  output bpa_pkg::result_t  result
);

  bpa_pkg::ctrl_cmd_t  cmd;
  bpa_pkg::ctrl_stat_t st;

  // sequencer: clearing pass, then one request at a time
  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // walk registers, node store and result beat
  bpa_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .st      (st),
    .done    (done),
    .result  (result)
  );

`ifndef ASSERT_OFF
  // result beat always lands with the block idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // an accepted beat makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  // a failed request carries no offset and no size
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.fail) |-> (result.page_offset_out == '0 && result.freed_pages == '0))
    else $error("fail beat with nonzero payload");

  // a released block is always a power of two
  a_freed_pow2: assert property (@(posedge clk) disable iff (rst)
    (done && result.freed_pages != '0) |-> $onehot(result.freed_pages))
    else $error("freed size not a power of two");
`endif

endmodule

// ----- dv/buddy_page_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb: self-checking bench for the buddy page allocator
// Request beats go in through start/busy. Each accepted beat is run through a
// private copy of the largest-free tree to predict its result beat. Every
// done beat is checked in order, field by field.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;

  localparam int LEAF_LOG2    = bpa_pkg::LEAF_LOG2;
  localparam int LEAF_PAGES   = bpa_pkg::LEAF_PAGES;
  localparam int SIZE_W       = bpa_pkg::SIZE_W;
  localparam int REQ_W        = bpa_pkg::REQ_W;
  localparam int OFS_W        = bpa_pkg::OFS_W;
  localparam int NODES        = 2 * LEAF_PAGES - 1;
  localparam int RANDOM_BEATS = 750;
  localparam int MAX_LIVE     = 48;       // cap on live blocks before frees take over
  localparam int DRAIN_CYCLES = 64;       // idle margin after the last predicted beat
  localparam int MAX_SHOWN    = 10;
  localparam int TIMEOUT_NS   = 2_000_000;

  // One directed row. The typed expectation is used only where typed is set.
  typedef struct {
    bpa_pkg::req_t    beat;
    bit               typed;
    bpa_pkg::result_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  bpa_pkg::req_t    request;
  logic             busy;
  logic             done;
  bpa_pkg::result_t result;

  buddy_page_allocator u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  // Shadow of the largest-free tree, heap order: children of n at 2n+1, 2n+2
  logic [SIZE_W-1:0] free_tree [NODES];

  bpa_pkg::result_t pending_results [$];   // predicted beats, oldest first
  bpa_pkg::result_t oldest_expected;
  int unsigned      live_ofs [$];          // blocks the shadow tree holds as allocated
  int unsigned      live_len [$];
  stim_row_t        directed_rows [$];
  int               gap_pct = 0;           // sender idle chance per cycle, percent
  int               phase_gap [4] = '{0, 69, 0, 38};

  int mismatches   = 0;
  int results_seen = 0;
  int alloc_ok     = 0;
  int alloc_fail   = 0;
  int free_ok      = 0;
  int free_fail    = 0;

  // Every node starts at its subtree size: 1 at the leaves, doubling upward.
  function automatic void tree_reset();
    for (int i = LEAF_PAGES - 1; i < NODES; i++) free_tree[i] = SIZE_W'(1);
    for (int i = LEAF_PAGES - 2; i >= 0; i--) free_tree[i] = free_tree[2*i+1] << 1;
  endfunction

  function automatic bpa_pkg::result_t predict_alloc(input logic [REQ_W-1:0] pages);
    int unsigned      want, span, node, lft, rgt;
    bpa_pkg::result_t res;
    res  = '0;
    want = 1;                          // zero pages still needs one
    while (want < pages) want = want << 1;
    if (want > free_tree[0]) begin
      res.fail = 1'b1;
      alloc_fail++;
      return res;
    end
    span = LEAF_PAGES;
    node = 0;
    while (span > want) begin
      lft  = 32'(free_tree[2*node+1]);
      rgt  = 32'(free_tree[2*node+2]);
      span = span >> 1;
      // best fit: the tighter child that still holds the block, left on a tie
      if (rgt < want || (want <= lft && lft <= rgt)) node = 2*node + 1;
      else node = 2*node + 2;
    end
    free_tree[node] = '0;
    res.page_offset_out = OFS_W'((node + 1) * span - LEAF_PAGES);
    live_ofs.push_back(32'(res.page_offset_out));
    live_len.push_back(span);
    while (node != 0) begin
      node = (node - 1) / 2;
      lft  = 32'(free_tree[2*node+1]);
      rgt  = 32'(free_tree[2*node+2]);
      free_tree[node] = SIZE_W'((lft > rgt) ? lft : rgt);
    end
    alloc_ok++;
    return res;
  endfunction

  function automatic bpa_pkg::result_t predict_free(input logic [OFS_W-1:0] page);
    int unsigned      node, span, lft, rgt;
    bpa_pkg::result_t res;
    res  = '0;
    node = 32'(page) + LEAF_PAGES - 1;
    span = 1;
    // climb to the used node that covers the page; none means it is free
    while (free_tree[node] != 0) begin
      if (node == 0) begin
        res.fail = 1'b1;
        free_fail++;
        return res;
      end
      node = (node - 1) / 2;
      span = span << 1;
    end
    free_tree[node] = SIZE_W'(span);
    res.freed_pages = REQ_W'(span);
    while (node != 0) begin
      node = (node - 1) / 2;
      span = span << 1;
      lft  = 32'(free_tree[2*node+1]);
      rgt  = 32'(free_tree[2*node+2]);
      // two whole free buddies merge into the parent block
      free_tree[node] = SIZE_W'((lft + rgt == span) ? span : ((lft > rgt) ? lft : rgt));
    end
    for (int k = 0; k < live_ofs.size(); k++) begin
      if (page >= live_ofs[k] && page < live_ofs[k] + live_len[k]) begin
        live_ofs.delete(k);
        live_len.delete(k);
        break;
      end
    end
    free_ok++;
    return res;
  endfunction

  function automatic bpa_pkg::result_t res_of(input int unsigned ofs,
                                              input int unsigned freed,
                                              input bit failed);
    bpa_pkg::result_t res;
    res.page_offset_out = OFS_W'(ofs);
    res.freed_pages     = REQ_W'(freed);
    res.fail            = failed;
    return res;
  endfunction

  function automatic stim_row_t row(input logic op, input int unsigned pages,
                                    input int unsigned page, input bit typed,
                                    input bpa_pkg::result_t want);
    stim_row_t r;
    r.beat.operation      = op;
    r.beat.request_pages  = REQ_W'(pages);
    r.beat.page_offset_in = OFS_W'(page);
    r.typed               = typed;
    r.want                = want;
    return r;
  endfunction

  // Random mix: frees of live blocks through any page inside them, some stray
  // frees, some raw request fields, the rest allocs biased to small sizes.
  function automatic bpa_pkg::req_t gen_random_beat();
    bpa_pkg::req_t beat;
    int unsigned   pick, k, lg;
    pick                = $urandom_range(0, 99);
    beat.operation      = bpa_pkg::OP_ALLOC;
    beat.request_pages  = REQ_W'($urandom);
    beat.page_offset_in = OFS_W'($urandom);
    if (live_ofs.size() != 0 && (pick < 40 || live_ofs.size() >= MAX_LIVE)) begin
      k = $urandom_range(0, live_ofs.size() - 1);
      beat.operation      = bpa_pkg::OP_FREE;
      beat.page_offset_in = OFS_W'(live_ofs[k] + $urandom_range(0, live_len[k] - 1));
    end else if (pick < 48) begin
      beat.operation = bpa_pkg::OP_FREE;        // stray page, usually already free
    end else if (pick >= 54) begin
      lg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LEAF_LOG2)
                                       : $urandom_range(0, 4);
      if (lg == 0) beat.request_pages = REQ_W'($urandom_range(0, 1));
      else beat.request_pages = REQ_W'($urandom_range((1 << (lg - 1)) + 1, 1 << lg));
    end
    return beat;
  endfunction

  // Present one beat and hold it until taken. Called and returns at a falling
  // edge. busy only moves on a rising edge, so busy low here means the beat
  // is taken at the next rising edge; the prediction is queued now.
  task automatic send_beat(input bpa_pkg::req_t beat, input bit typed,
                           input bpa_pkg::result_t want);
    bpa_pkg::result_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= beat;
    while (busy !== 1'b0) @(negedge clk);
    if (beat.operation == bpa_pkg::OP_ALLOC) predicted = predict_alloc(beat.request_pages);
    else predicted = predict_free(beat.page_offset_in);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Result checker: a done beat cannot be held off, so it is taken every time
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result beat with nothing pending: ofs %0d freed %0d fail %b",
                   $time, result.page_offset_out, result.freed_pages, result.fail);
      end else begin
        oldest_expected = pending_results.pop_front();
        if (result.page_offset_out !== oldest_expected.page_offset_out ||
            result.freed_pages     !== oldest_expected.freed_pages ||
            result.fail            !== oldest_expected.fail) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: mismatch: exp ofs %0d freed %0d fail %b, %s %0d freed %0d fail %b",
                     $time, oldest_expected.page_offset_out, oldest_expected.freed_pages,
                     oldest_expected.fail, "got ofs", result.page_offset_out,
                     result.freed_pages, result.fail);
        end
      end
    end
  end

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    tree_reset();

    // Fresh tree: one block spans every page, after that nothing is left.
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 1024, 10'h3FF, 1, res_of(0, 0, 0)));
    // Full tree: even a zero request (one page) fails.
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 0, 0, 1, res_of(0, 0, 1)));
    // Any page of the block frees all of it; request field ignored on a free.
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 11'h7FF, 10'h2A5, 1, res_of(0, 1024, 0)));
    // Free of pages that are not allocated.
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 5, 1, res_of(0, 0, 1)));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 1023, 1, res_of(0, 0, 1)));
    // Requests above the page count, up to the all-ones field.
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 1025, 0, 1, res_of(0, 0, 1)));
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 2047, 0, 1, res_of(0, 0, 1)));
    // Zero counts as one page and lands on page 0.
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 0, 10'h3FF, 1, res_of(0, 0, 0)));
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 1, 0, 0, '0));
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 3, 0, 0, '0));      // rounds to 4
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 512, 0, 0, '0));    // takes the upper half
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 512, 0, 1, res_of(0, 0, 1)));
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 1000, 0, 1, res_of(0, 0, 1)));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 777, 0, '0));     // page inside the half
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 777, 1, res_of(0, 0, 1)));
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 257, 0, 0, '0));    // rounds to 512
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 2, 0, 0, '0));
    // Release everything so buddies merge back to one block.
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 1, 0, '0));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 0, 0, '0));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 3, 0, '0));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 6, 0, '0));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 512, 0, '0));
    directed_rows.push_back(row(bpa_pkg::OP_ALLOC, 1024, 0, 1, res_of(0, 0, 0)));
    directed_rows.push_back(row(bpa_pkg::OP_FREE, 0, 1023, 1, res_of(0, 1024, 0)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;        // the clearing sweep follows; busy holds beats off

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    // Gap phases: none, sender sparse, receiver-stall slot, both. The result
    // side cannot stall, so that slot runs back to back like the first.
    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_gap[p];
      repeat (RANDOM_BEATS / 4) send_beat(gen_random_beat(), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d result beats from %0d directed rows and %0d random beats",
             results_seen, directed_rows.size(), 4 * (RANDOM_BEATS / 4));
    $display("allocs placed %0d, refused %0d; frees done %0d, refused %0d; mismatches %0d",
             alloc_ok, alloc_fail, free_ok, free_fail, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (clearing sweep plus ~800
  // beats with sender gaps).
  initial begin
    #TIMEOUT_NS;
    $display("TB_ERROR");
    $finish;
  end

endmodule
